FILE: sv/assert_macros.svh
// assertion helpers used by voxel_face_culler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: sv/vfc_pkg.sv
package vfc_pkg;

   localparam int CMD_W     = 2;
   localparam int COORD_W   = 6;
   localparam int CFG_W     = 3;
   localparam int MASK_W    = 6;
   localparam int CNT_W     = 3;
   localparam int COUNTER_W = 17;
   localparam int STEP_W    = 3;
   localparam int CSR_IDX_W = 2;

   // four vertices per face
   localparam int VERT_SHIFT = 2;
   localparam int CFG_RESET  = 4;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MESH  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNKS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNKS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNKS_Z = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // step 0 reads the voxel itself, steps 1..6 its face neighbors
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_PROBE   = 5'b00100,
      ST_COLLECT = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   typedef struct packed {
      logic       move;
      logic [1:0] axis;
      logic       neg;
   } probe_dir_type;

   localparam probe_dir_type DIR_CENTER = '{move: 1'b0, axis: AXIS_X, neg: 1'b0};

   // face order: -X, +X, +Z, -Z, +Y, -Y
   function automatic probe_dir_type face_dir(input logic [STEP_W-1:0] step);
      probe_dir_type d;
      d = DIR_CENTER;
      unique case (step)
         3'd1: d = '{move: 1'b1, axis: AXIS_X, neg: 1'b1};
         3'd2: d = '{move: 1'b1, axis: AXIS_X, neg: 1'b0};
         3'd3: d = '{move: 1'b1, axis: AXIS_Z, neg: 1'b0};
         3'd4: d = '{move: 1'b1, axis: AXIS_Z, neg: 1'b1};
         3'd5: d = '{move: 1'b1, axis: AXIS_Y, neg: 1'b0};
         3'd6: d = '{move: 1'b1, axis: AXIS_Y, neg: 1'b1};
         default: d = DIR_CENTER;
      endcase
      return d;
   endfunction

endpackage

FILE: sv/vfc_ram.sv
module vfc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

FILE: sv/vfc_probe.sv
module vfc_probe #(
   parameter int AXIS_W = 6,
   parameter int EXT_W  = 7
) (
   input  logic [vfc_pkg::COORD_W-1:0] pos_x,
   input  logic [vfc_pkg::COORD_W-1:0] pos_y,
   input  logic [vfc_pkg::COORD_W-1:0] pos_z,
   input  vfc_pkg::probe_dir_type      dir,
   input  logic [EXT_W-1:0]            ext_x,
   input  logic [EXT_W-1:0]            ext_y,
   input  logic [EXT_W-1:0]            ext_z,
   output logic                        in_world,
   output logic [3*AXIS_W-1:0]         addr
);
   import vfc_pkg::*;

   localparam int CMP_W = (EXT_W > COORD_W + 1) ? EXT_W : COORD_W + 1;

   logic [COORD_W-1:0] pos_a [3];
   logic [EXT_W-1:0]   ext_a [3];
   logic [CMP_W-1:0]   coord [3];
   logic [2:0]         ok;

   always_comb begin
      pos_a[0] = pos_x;
      pos_a[1] = pos_y;
      pos_a[2] = pos_z;
      ext_a[0] = ext_x;
      ext_a[1] = ext_y;
      ext_a[2] = ext_z;
      for (int a = 0; a < 3; a++) begin
         coord[a] = CMP_W'(pos_a[a]);
         ok[a]    = 1'b1;
         if (dir.move && (dir.axis == 2'(a))) begin
            if (dir.neg) begin
               // stepping below zero leaves the world
               ok[a]    = (pos_a[a] != '0);
               coord[a] = CMP_W'(pos_a[a]) - CMP_W'(1);
            end else begin
               coord[a] = CMP_W'(pos_a[a]) + CMP_W'(1);
            end
         end
         ok[a] = ok[a] && (coord[a] < CMP_W'(ext_a[a]));
      end
      in_world = &ok;
      addr     = {coord[2][AXIS_W-1:0], coord[1][AXIS_W-1:0], coord[0][AXIS_W-1:0]};
   end

endmodule

FILE: sv/voxel_face_culler.sv
// Voxel face culler: one occupancy bit per voxel of a world made of cubic chunks, and a
// face-exposure query for meshing. Write, start and unused commands leave the block idle,
// ready for the next command. A mesh command makes 7 reads of the single-port occupancy
// memory, one for the voxel and one per face neighbor, then collects the last read data and
// loads the result register; no new command is taken before that load. The result then
// waits in its own register while the next write or start is accepted, but the next mesh
// command finishes only once that result has been taken. After reset the occupancy memory
// is swept to empty one entry a cycle, all 2**(3*clog2(CHUNK_EDGE*MAX_CHUNKS_PER_AXIS))
// entries (262144 with the defaults), during which no command is accepted; configuration
// writes are taken at any time.
`include "assert_macros.svh"

module voxel_face_culler #(
   parameter int CHUNK_EDGE          = 16,
   parameter int MAX_CHUNKS_PER_AXIS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vfc_pkg::CMD_W-1:0]     req_command,
   input  logic [vfc_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [vfc_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [vfc_pkg::COORD_W-1:0]   req_pos_z,
   input  logic                          req_occupied,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vfc_pkg::MASK_W-1:0]    rsp_face_mask,
   output logic [vfc_pkg::CNT_W-1:0]     rsp_face_count,
   output logic [vfc_pkg::COUNTER_W-1:0] rsp_vertex_base,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vfc_pkg::CFG_W-1:0]     csr_data
);
   import vfc_pkg::*;

   // store geometry: each axis gets its own address field
   localparam int STORE_SIDE = CHUNK_EDGE * MAX_CHUNKS_PER_AXIS;
   localparam int AXIS_W     = $clog2(STORE_SIDE);
   localparam int EXT_W      = $clog2(STORE_SIDE + 1);
   localparam int ADDR_W     = 3 * AXIS_W;
   localparam int DEPTH      = 2 ** ADDR_W;

   // chunk count saturation
   localparam int SAT_W = ($clog2(MAX_CHUNKS_PER_AXIS + 1) > CFG_W) ?
                          $clog2(MAX_CHUNKS_PER_AXIS + 1) : CFG_W;
   localparam logic [SAT_W-1:0] SAT_MAX   = SAT_W'(MAX_CHUNKS_PER_AXIS);
   localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(((CFG_RESET > MAX_CHUNKS_PER_AXIS) ?
                                            MAX_CHUNKS_PER_AXIS : CFG_RESET) * CHUNK_EDGE);

   // control state
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNTER_W-1:0] counter_ff, counter_in;
   logic [EXT_W-1:0]     ext_ff [3];
   logic [EXT_W-1:0]     ext_in [3];
   logic                 rsp_valid_ff, rsp_valid_in;

   // per-transaction payload
   logic [COORD_W-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_W-1:0]   pos_y_ff, pos_y_in;
   logic [COORD_W-1:0]   pos_z_ff, pos_z_in;
   logic                 hit_ff, hit_in;
   logic                 center_ff, center_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [CNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic [COUNTER_W-1:0] rsp_base_ff, rsp_base_in;

   // shared probe unit and memory port
   logic [COORD_W-1:0]   probe_x, probe_y, probe_z;
   probe_dir_type        probe_dir;
   logic                 probe_inside;
   logic [ADDR_W-1:0]    probe_addr;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_addr;
   logic                 ram_wdata;
   logic                 ram_rdata;

   logic                 sample;
   logic                 done_go;
   logic [SAT_W-1:0]     csr_sat;
   logic [EXT_W-1:0]     csr_ext;

   // bounds check and address for the voxel or one of its neighbors
   vfc_probe #(
      .AXIS_W (AXIS_W),
      .EXT_W  (EXT_W)
   ) u_probe (
      .pos_x    (probe_x),
      .pos_y    (probe_y),
      .pos_z    (probe_z),
      .dir      (probe_dir),
      .ext_x    (ext_ff[0]),
      .ext_y    (ext_ff[1]),
      .ext_z    (ext_ff[2]),
      .in_world (probe_inside),
      .addr     (probe_addr)
   );

   // occupancy store, single port, registered read
   vfc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // saturated chunk count times chunk edge gives the axis extent
   always_comb begin
      csr_sat = (SAT_W'(csr_data) > SAT_MAX) ? SAT_MAX : SAT_W'(csr_data);
      csr_ext = EXT_W'(EXT_W'(csr_sat) * EXT_W'(CHUNK_EDGE));
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      counter_in  = counter_ff;
      ext_in      = ext_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      pos_z_in    = pos_z_ff;
      hit_in      = hit_ff;
      center_in   = center_ff;
      mask_in     = mask_ff;
      cnt_in      = cnt_ff;
      rsp_mask_in = rsp_mask_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_base_in = rsp_base_ff;

      // result register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      done_go      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      // the probe sees the live command while idle, the latched one otherwise
      if (state_ff == ST_IDLE) begin
         probe_x = req_pos_x;
         probe_y = req_pos_y;
         probe_z = req_pos_z;
      end else begin
         probe_x = pos_x_ff;
         probe_y = pos_y_ff;
         probe_z = pos_z_ff;
      end
      probe_dir = DIR_CENTER;

      ram_we    = 1'b0;
      ram_addr  = probe_addr;
      ram_wdata = 1'b0;

      // out-of-world reads count as empty
      sample = hit_ff && ram_rdata;

      // read data for step s arrives while step_ff holds s+1
      if (((state_ff == ST_PROBE) || (state_ff == ST_COLLECT)) && (step_ff != STEP_CENTER)) begin
         if (step_ff == STEP_W'(1)) begin
            center_in = sample;
         end else begin
            mask_in[3'(step_ff - STEP_W'(2))] = !sample;
            cnt_in = cnt_ff + CNT_W'(!sample);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // post-reset sweep, every voxel empty
            ram_addr    = clr_addr_ff;
            ram_we      = 1'b1;
            ram_wdata   = 1'b0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               unique case (req_command)
                  CMD_WRITE: begin
                     // writes outside the world are dropped
                     ram_we    = probe_inside;
                     ram_wdata = req_occupied;
                  end
                  CMD_START: begin
                     counter_in = '0;
                  end
                  CMD_MESH: begin
                     state_in = ST_PROBE;
                     step_in  = STEP_CENTER;
                     mask_in  = '0;
                     cnt_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            probe_dir = face_dir(step_ff);
            hit_in    = probe_inside;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            // last neighbor read lands this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               rsp_base_in  = counter_ff;
               if (center_ff) begin
                  rsp_mask_in = mask_ff;
                  rsp_cnt_in  = cnt_ff;
                  counter_in  = counter_ff + (COUNTER_W'(cnt_ff) << VERT_SHIFT);
               end else begin
                  // empty voxel shows no faces
                  rsp_mask_in = '0;
                  rsp_cnt_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes, unknown indexes ignored
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHUNKS_X: ext_in[0] = csr_ext;
            CSR_CHUNKS_Y: ext_in[1] = csr_ext;
            CSR_CHUNKS_Z: ext_in[2] = csr_ext;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= STEP_CENTER;
         counter_ff   <= '0;
         ext_ff[0]    <= EXT_RESET;
         ext_ff[1]    <= EXT_RESET;
         ext_ff[2]    <= EXT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         counter_ff   <= counter_in;
         ext_ff       <= ext_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      hit_ff      <= hit_in;
      center_ff   <= center_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_base_ff <= rsp_base_in;
   end

   // commands only while idle, registers always
   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_mask   = rsp_mask_ff;
   assign rsp_face_count  = rsp_cnt_ff;
   assign rsp_vertex_base = rsp_base_ff;

   `ASSERT_CLK(a_state_onehot, clock, reset, $onehot(state_ff))
   `ASSERT_CLK(a_count_matches_mask, clock, reset,
               rsp_valid |-> (rsp_face_count == CNT_W'($countones(rsp_face_mask))))
   `ASSERT_CLK(a_empty_keeps_counter, clock, reset,
               (done_go && !center_ff) |=> (counter_ff == $past(counter_ff)))
   `ASSERT_CLK(a_probe_step_range, clock, reset, (state_ff == ST_PROBE) |-> (step_ff <= STEP_LAST))
   `ASSERT_NEVER(a_write_only_idle_or_clear, clock, reset,
                 ram_we && (state_ff != ST_CLEAR) && (state_ff != ST_IDLE))

endmodule
